### design/pffa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pffa_pkg
// Shared types, codes and constants of the page frame free list allocator.
// ----------------------------------------------------------------------------
package pffa_pkg;

   localparam int NUM_FRAMES_DEFAULT  = 256;
   localparam int MAX_REQUEST_DEFAULT = 16;

   localparam int OP_W    = 2;
   localparam int REQ_W   = 5;
   localparam int FRAME_W = 8;
   localparam int COUNT_W = 8;
   localparam int FC_W    = 9;

   localparam logic [FC_W-1:0]    FRAME_COUNT_RESET = 9'd256;
   localparam logic [COUNT_W-1:0] COUNT_MAX         = 8'hFF;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
   localparam logic [OP_W-1:0] OP_REBUILD = 2'd2;

   localparam logic [1:0] KIND_ALLOC   = 2'd0;
   localparam logic [1:0] KIND_FREE    = 2'd1;
   localparam logic [1:0] KIND_REBUILD = 2'd2;
   localparam logic [1:0] KIND_NOP     = 2'd3;

   typedef struct packed {
      logic [1:0]         kind;
      logic [REQ_W-1:0]   count;
      logic [FRAME_W-1:0] frame;
      logic               zero_len;
      logic               over_max;
      logic               in_range;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

### design/pffa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pffa_front
// Accepts request beats, classifies them and pushes a command into the queue.
// ----------------------------------------------------------------------------
module pffa_front #(
   parameter int NUM_FRAMES  = pffa_pkg::NUM_FRAMES_DEFAULT,
   parameter int MAX_REQUEST = pffa_pkg::MAX_REQUEST_DEFAULT
) (
   input  logic                          start,
   output logic                          busy,
   input  logic [pffa_pkg::OP_W-1:0]     req_opcode,
   input  logic [pffa_pkg::REQ_W-1:0]    req_request_count,
   input  logic [pffa_pkg::FRAME_W-1:0]  req_free_frame,
   input  pffa_pkg::q_status_type        q_status,
   output logic                          push,
   output pffa_pkg::cmd_type             cmd
);

   assign busy = q_status.full;
   assign push = start && !q_status.full;

   always_comb begin
      cmd.count    = req_request_count;
      cmd.frame    = req_free_frame;
      cmd.zero_len = (req_request_count == '0);
      cmd.over_max = (32'(req_request_count) > MAX_REQUEST);
      cmd.in_range = (32'(req_free_frame) < NUM_FRAMES);
      unique case (req_opcode)
         pffa_pkg::OP_ALLOC:   cmd.kind = pffa_pkg::KIND_ALLOC;
         pffa_pkg::OP_FREE:    cmd.kind = pffa_pkg::KIND_FREE;
         pffa_pkg::OP_REBUILD: cmd.kind = pffa_pkg::KIND_REBUILD;
         default:              cmd.kind = pffa_pkg::KIND_NOP;
      endcase
   end

endmodule

### design/pffa_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pffa_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module pffa_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  pffa_pkg::cmd_type      push_cmd,
   input  logic                   pop,
   output pffa_pkg::cmd_type      head_cmd,
   output pffa_pkg::q_status_type status
);

   localparam int DEPTH = pffa_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pffa_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              do_push, do_pop;

   assign status.empty = (fill_ff == '0);
   assign status.full  = (fill_ff == CNT_W'(DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_cmd     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### design/pffa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pffa_back
// Executes commands: link memory, list head, free count and result beats.
// ----------------------------------------------------------------------------
module pffa_back #(
   parameter int NUM_FRAMES  = pffa_pkg::NUM_FRAMES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pffa_pkg::cmd_type              cmd,
   input  pffa_pkg::q_status_type         q_status,
   output logic                           pop,
   input  logic [pffa_pkg::FC_W-1:0]      frame_count,
   output logic                           rsp_strobe,
   output logic                           rsp_status,
   output logic                           rsp_frame_valid,
   output logic [pffa_pkg::FRAME_W-1:0]   rsp_alloc_frame,
   output logic                           rsp_last,
   output logic [pffa_pkg::COUNT_W-1:0]   rsp_frames_free
);

   localparam int LINK_DEPTH = (NUM_FRAMES < 256) ? NUM_FRAMES : 256;
   localparam int ADDR_W     = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
   localparam int FC_W       = pffa_pkg::FC_W;
   localparam int FRAME_W    = pffa_pkg::FRAME_W;
   localparam int COUNT_W    = pffa_pkg::COUNT_W;
   localparam int REQ_W      = pffa_pkg::REQ_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_NEXT = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [FRAME_W-1:0]    head_ff, head_in;
   logic [COUNT_W-1:0]    total_ff, total_in;
   logic [FC_W-1:0]       span_ff, span_in;
   logic [REQ_W-1:0]      remain_ff, remain_in;
   logic [COUNT_W-1:0]    final_ff, final_in;

   logic [FRAME_W-1:0]    link_mem [LINK_DEPTH];
   logic [LINK_DEPTH-1:0] link_ok_ff;
   logic [FRAME_W-1:0]    rd_data_ff;
   logic                  rd_hit_ff;
   logic [ADDR_W-1:0]     rd_addr_ff;
   logic [ADDR_W-1:0]     head_addr;

   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic                  clear_all;

   logic [FC_W-1:0]       eff_count;
   logic [FC_W-1:0]       rd_idx;
   logic [FRAME_W-1:0]    link_dflt;
   logic [FRAME_W-1:0]    link_word;

   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic                  rsp_status_ff, rsp_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]    rsp_frame_ff, rsp_frame_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [COUNT_W-1:0]    rsp_free_ff, rsp_free_in;

   assign head_addr = head_ff[ADDR_W-1:0];

   always_comb begin
      if (frame_count < FC_W'(2)) begin
         eff_count = FC_W'(2);
      end else if (frame_count > FC_W'(LINK_DEPTH)) begin
         eff_count = FC_W'(LINK_DEPTH);
      end else begin
         eff_count = frame_count;
      end
   end

   // unwritten entries read as the rebuilt ascending chain
   always_comb begin
      rd_idx = FC_W'(rd_addr_ff);
      if ((rd_idx != '0) && ((rd_idx + 1'b1) < span_ff)) begin
         link_dflt = FRAME_W'(rd_idx + 1'b1);
      end else begin
         link_dflt = '0;
      end
      link_word = rd_hit_ff ? rd_data_ff : link_dflt;
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      total_in      = total_ff;
      span_in       = span_ff;
      remain_in     = remain_ff;
      final_in      = final_ff;
      pop           = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = cmd.frame[ADDR_W-1:0];
      clear_all     = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_status_in = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_frame_in  = '0;
      rsp_last_in   = 1'b1;
      rsp_free_in   = total_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               unique case (cmd.kind)
                  pffa_pkg::KIND_ALLOC: begin
                     if (cmd.over_max || (COUNT_W'(cmd.count) > total_ff)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = 1'b1;
                     end else if (cmd.zero_len) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        remain_in = cmd.count;
                        final_in  = total_ff - COUNT_W'(cmd.count);
                        state_in  = ST_READ;
                     end
                  end
                  pffa_pkg::KIND_FREE: begin
                     if (cmd.in_range) begin
                        mem_we   = 1'b1;
                        head_in  = cmd.frame;
                        total_in = (total_ff == pffa_pkg::COUNT_MAX) ?
                                   total_ff : total_ff + 1'b1;
                     end
                     rsp_strobe_in = 1'b1;
                     rsp_free_in   = total_in;
                  end
                  pffa_pkg::KIND_REBUILD: begin
                     clear_all     = 1'b1;
                     span_in       = eff_count;
                     head_in       = FRAME_W'(1);
                     total_in      = COUNT_W'(eff_count - 1'b1);
                     rsp_strobe_in = 1'b1;
                     rsp_free_in   = total_in;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            rsp_strobe_in = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_frame_in  = head_ff;
            rsp_last_in   = (remain_ff == REQ_W'(1));
            rsp_free_in   = final_ff;
            head_in       = link_word;
            total_in      = total_ff - 1'b1;
            remain_in     = remain_ff - 1'b1;
            state_in      = (remain_ff == REQ_W'(1)) ? ST_IDLE : ST_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= FRAME_W'(1);
         total_ff      <= COUNT_W'(LINK_DEPTH - 1);
         span_ff       <= FC_W'(LINK_DEPTH);
         remain_ff     <= '0;
         final_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         total_ff      <= total_in;
         span_ff       <= span_in;
         remain_ff     <= remain_in;
         final_ff      <= final_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_valid_ff  <= rsp_valid_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_free_ff   <= rsp_free_in;
   end

   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         link_ok_ff <= '0;
      end else if (mem_we) begin
         link_ok_ff[mem_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= head_ff;
      end
      rd_data_ff <= link_mem[head_addr];
      rd_hit_ff  <= link_ok_ff[head_addr];
      rd_addr_ff <= head_addr;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_frame_valid = rsp_valid_ff;
   assign rsp_alloc_frame = rsp_frame_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_frames_free = rsp_free_ff;

endmodule

### design/page_frame_free_list_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_free_list_allocator
// Linked free list of page frames with allocate, free and rebuild commands.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low; busy rises only
// while the two-entry command queue is full. Results leave as strobed beats on
// the rsp_ ports and cannot be held off. Free, rebuild and the unused opcode
// are handled in the back end's idle state: each is written into the queue,
// popped, and its single result strobe is registered in the back end. An
// allocate of n frames passes from idle through a read and a next state per
// frame, set by one registered link memory read per frame; a rejected or
// zero-length allocate answers from idle with a single beat. Rebuild clears
// per-entry written flags at once, so no clearing pass follows reset or
// rebuild. A frame_count write takes effect at the next rebuild.
// ----------------------------------------------------------------------------
module page_frame_free_list_allocator #(
   parameter int NUM_FRAMES  = pffa_pkg::NUM_FRAMES_DEFAULT,
   parameter int MAX_REQUEST = pffa_pkg::MAX_REQUEST_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [pffa_pkg::OP_W-1:0]     req_opcode,
   input  logic [pffa_pkg::REQ_W-1:0]    req_request_count,
   input  logic [pffa_pkg::FRAME_W-1:0]  req_free_frame,
   output logic                          rsp_strobe,
   output logic                          rsp_status,
   output logic                          rsp_frame_valid,
   output logic [pffa_pkg::FRAME_W-1:0]  rsp_alloc_frame,
   output logic                          rsp_last,
   output logic [pffa_pkg::COUNT_W-1:0]  rsp_frames_free,
   input  logic                          csr_wr_en,
   input  logic [pffa_pkg::FC_W-1:0]     csr_wr_data
);

   logic [pffa_pkg::FC_W-1:0] frame_count_ff;
   logic                      push;
   logic                      pop;
   pffa_pkg::cmd_type         push_cmd;
   pffa_pkg::cmd_type         head_cmd;
   pffa_pkg::q_status_type    q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= pffa_pkg::FRAME_COUNT_RESET;
      end else if (csr_wr_en) begin
         frame_count_ff <= csr_wr_data;
      end
   end

   pffa_front #(
      .NUM_FRAMES  (NUM_FRAMES),
      .MAX_REQUEST (MAX_REQUEST)
   ) u_front (
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_request_count (req_request_count),
      .req_free_frame    (req_free_frame),
      .q_status          (q_status),
      .push              (push),
      .cmd               (push_cmd)
   );

   pffa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   pffa_back #(
      .NUM_FRAMES  (NUM_FRAMES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd             (head_cmd),
      .q_status        (q_status),
      .pop             (pop),
      .frame_count     (frame_count_ff),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_frame_valid (rsp_frame_valid),
      .rsp_alloc_frame (rsp_alloc_frame),
      .rsp_last        (rsp_last),
      .rsp_frames_free (rsp_frames_free)
   );

`ifndef SYNTHESIS
   a_fail_is_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status) |-> (rsp_last && !rsp_frame_valid))
      else $error("failed allocate must be a single frameless last beat");

   a_burst_spacing: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> !rsp_strobe ##1 rsp_strobe)
      else $error("allocate burst beat missing or early");

   a_burst_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> ##1 (rsp_frames_free == $past(rsp_frames_free, 2)))
      else $error("free count changed within an allocate burst");

   a_burst_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> (rsp_frame_valid && !rsp_status))
      else $error("non-final beat without a frame");
`endif

endmodule

### test/page_frame_free_list_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_free_list_allocator_tb
// Self-checking bench for the page frame free list allocator. A predictor
// keeps its own link store, head, free count and frame_count register, works
// out the response beats of every accepted request beat and matches them in
// order against the rsp_ ports. Directed requests cover zero-length, oversize
// and failing allocates, frame zero, double free, count saturation, the
// unused opcode and the smallest list. Random phases under several
// frame_count settings then mostly allocate and hand the same frames back.
// ----------------------------------------------------------------------------
module page_frame_free_list_allocator_tb;

   localparam int OP_W    = pffa_pkg::OP_W;
   localparam int REQ_W   = pffa_pkg::REQ_W;
   localparam int FRAME_W = pffa_pkg::FRAME_W;
   localparam int COUNT_W = pffa_pkg::COUNT_W;
   localparam int FC_W    = pffa_pkg::FC_W;

   localparam logic [OP_W-1:0]    OP_ALLOC          = pffa_pkg::OP_ALLOC;
   localparam logic [OP_W-1:0]    OP_FREE           = pffa_pkg::OP_FREE;
   localparam logic [OP_W-1:0]    OP_REBUILD        = pffa_pkg::OP_REBUILD;
   localparam logic [OP_W-1:0]    OP_UNUSED         = 2'd3;
   localparam logic [FC_W-1:0]    FRAME_COUNT_RESET = pffa_pkg::FRAME_COUNT_RESET;
   localparam logic [COUNT_W-1:0] COUNT_MAX         = pffa_pkg::COUNT_MAX;

   localparam int              NUM_FRAMES  = pffa_pkg::NUM_FRAMES_DEFAULT;
   localparam int              MAX_REQUEST = pffa_pkg::MAX_REQUEST_DEFAULT;
   localparam int              CYCLE_LIMIT = 200000;
   localparam int              SETTLE      = 6;
   localparam int              PHASE_ITEMS = 55;

   typedef struct {
      logic               status;
      logic               frame_valid;
      logic [FRAME_W-1:0] alloc_frame;
      logic               is_last;
      logic [COUNT_W-1:0] frames_free;
   } rsp_beat_type;

   class frame_list_scoreboard;
      logic [FRAME_W-1:0] link_mem [NUM_FRAMES];
      logic [FRAME_W-1:0] head;
      logic [COUNT_W-1:0] free_cnt;
      logic [FC_W-1:0]    frame_count_reg;
      rsp_beat_type       expected_q [$];
      logic [FRAME_W-1:0] held_frames [$];
      int                 errors;
      int                 beats_checked;
      int                 grants;
      int                 refusals;

      function new();
         frame_count_reg = FRAME_COUNT_RESET;
         errors          = 0;
         beats_checked   = 0;
         grants          = 0;
         refusals        = 0;
         rebuild_list();
      endfunction

      function void rebuild_list();
         int n;
         n = int'(frame_count_reg);
         if (n < 2) n = 2;
         if (n > NUM_FRAMES) n = NUM_FRAMES;
         foreach (link_mem[i]) link_mem[i] = '0;
         for (int f = 1; f + 1 < n; f++) link_mem[f] = FRAME_W'(f + 1);
         head     = FRAME_W'(1);
         free_cnt = COUNT_W'(n - 1);
         held_frames.delete();
      endfunction

      function void add_beat(logic status, logic valid, logic [FRAME_W-1:0] frame,
                             logic is_last);
         rsp_beat_type b;
         b.status      = status;
         b.frame_valid = valid;
         b.alloc_frame = frame;
         b.is_last     = is_last;
         b.frames_free = free_cnt;
         expected_q    = {expected_q, b};
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [REQ_W-1:0] cnt,
                                 logic [FRAME_W-1:0] frame);
         logic [FRAME_W-1:0] got [$];
         case (op)
            OP_ALLOC: begin
               if (cnt > MAX_REQUEST || cnt > free_cnt) begin
                  refusals++;
                  add_beat(1'b1, 1'b0, '0, 1'b1);
               end else if (cnt == 0) begin
                  add_beat(1'b0, 1'b0, '0, 1'b1);
               end else begin
                  grants++;
                  for (int i = 0; i < cnt; i++) begin
                     got         = {got, head};
                     held_frames = {held_frames, head};
                     head        = link_mem[head];
                     free_cnt    = free_cnt - 1'b1;
                  end
                  for (int i = 0; i < cnt; i++)
                     add_beat(1'b0, 1'b1, got[i], i + 1 == cnt);
               end
            end
            OP_FREE: begin
               link_mem[frame] = head;
               head            = frame;
               if (free_cnt < COUNT_MAX) free_cnt = free_cnt + 1'b1;
               add_beat(1'b0, 1'b0, '0, 1'b1);
            end
            OP_REBUILD: begin
               rebuild_list();
               add_beat(1'b0, 1'b0, '0, 1'b1);
            end
            default: add_beat(1'b0, 1'b0, '0, 1'b1);
         endcase
      endfunction

      function void compare_field(string name, int exp_val, int act_val);
         if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            errors++;
         end
      endfunction

      function void check_result(logic status, logic valid, logic [FRAME_W-1:0] frame,
                                 logic is_last, logic [COUNT_W-1:0] frames_free);
         rsp_beat_type b;
         if (expected_q.size() == 0) begin
            $error("response beat with nothing outstanding");
            errors++;
            return;
         end
         b = expected_q.pop_front();
         beats_checked++;
         compare_field("rsp_status", int'(b.status), int'(status));
         compare_field("rsp_frame_valid", int'(b.frame_valid), int'(valid));
         compare_field("rsp_alloc_frame", int'(b.alloc_frame), int'(frame));
         compare_field("rsp_last", int'(b.is_last), int'(is_last));
         compare_field("rsp_frames_free", int'(b.frames_free), int'(frames_free));
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [OP_W-1:0]     req_opcode;
   logic [REQ_W-1:0]    req_request_count;
   logic [FRAME_W-1:0]  req_free_frame;
   logic                rsp_strobe;
   logic                rsp_status;
   logic                rsp_frame_valid;
   logic [FRAME_W-1:0]  rsp_alloc_frame;
   logic                rsp_last;
   logic [COUNT_W-1:0]  rsp_frames_free;
   logic                csr_wr_en;
   logic [FC_W-1:0]     csr_wr_data;

   frame_list_scoreboard alloc_sb;
   int                   cycle_cnt;
   int                   requests_sent;
   int                   csr_writes;

   page_frame_free_list_allocator i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_request_count (req_request_count),
      .req_free_frame    (req_free_frame),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_frame_valid   (rsp_frame_valid),
      .rsp_alloc_frame   (rsp_alloc_frame),
      .rsp_last          (rsp_last),
      .rsp_frames_free   (rsp_frames_free),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_cnt);
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         alloc_sb.check_result(rsp_status, rsp_frame_valid, rsp_alloc_frame, rsp_last,
                               rsp_frames_free);
   end

   // hold the beat until busy is low at a rising edge
   task automatic send_request(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] cnt,
                               input logic [FRAME_W-1:0] frame);
      start             = 1'b1;
      req_opcode        = op;
      req_request_count = cnt;
      req_free_frame    = frame;
      do @(posedge clock); while (busy);
      alloc_sb.note_request(op, cnt, frame);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic idle_burst(input bit allowed);
      if (allowed && $urandom_range(0, 3) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
   endtask

   task automatic drain();
      start = 1'b0;
      while (alloc_sb.expected_q.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_frame_count(input logic [FC_W-1:0] value);
      drain();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      alloc_sb.frame_count_reg = value;
      csr_writes++;
   endtask

   task automatic send_random_item();
      int                 pick;
      int                 idx;
      int                 room;
      logic [REQ_W-1:0]   cnt;
      logic [FRAME_W-1:0] frame;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         room = alloc_sb.free_cnt < MAX_REQUEST ? int'(alloc_sb.free_cnt) : MAX_REQUEST;
         idx  = $urandom_range(0, 9);
         if (idx == 0) cnt = REQ_W'($urandom_range(MAX_REQUEST + 1, 31));
         else if (idx < 3) cnt = REQ_W'($urandom_range(0, MAX_REQUEST));
         else cnt = REQ_W'($urandom_range(0, room));
         send_request(OP_ALLOC, cnt, FRAME_W'($urandom));
      end else if (pick < 88) begin
         if (alloc_sb.held_frames.size() != 0 && $urandom_range(0, 3) != 0) begin
            idx   = $urandom_range(0, alloc_sb.held_frames.size() - 1);
            frame = alloc_sb.held_frames[idx];
            alloc_sb.held_frames.delete(idx);
         end else begin
            frame = FRAME_W'($urandom_range(0, 255));
         end
         send_request(OP_FREE, REQ_W'($urandom), frame);
      end else if (pick < 94) begin
         send_request(OP_REBUILD, REQ_W'($urandom), FRAME_W'($urandom));
      end else begin
         send_request(OP_UNUSED, REQ_W'($urandom), FRAME_W'($urandom));
      end
   endtask

   initial begin
      logic [FC_W-1:0] phase_counts [8];
      alloc_sb          = new();
      cycle_cnt         = 0;
      requests_sent     = 0;
      csr_writes        = 0;
      reset             = 1'b1;
      start             = 1'b0;
      req_opcode        = OP_ALLOC;
      req_request_count = '0;
      req_free_frame    = '0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      send_request(OP_ALLOC, 5'd0, 8'd0);
      send_request(OP_ALLOC, 5'd1, 8'd0);
      send_request(OP_ALLOC, 5'd16, 8'd0);
      send_request(OP_ALLOC, 5'd17, 8'd0);
      send_request(OP_ALLOC, 5'd31, 8'hFF);
      send_request(OP_FREE, 5'd0, 8'd0);
      send_request(OP_FREE, 5'd0, 8'd255);
      send_request(OP_FREE, 5'd0, 8'd255);
      send_request(OP_UNUSED, 5'd31, 8'hFF);
      send_request(OP_ALLOC, 5'd3, 8'd0);
      send_request(OP_REBUILD, 5'd0, 8'd0);
      send_request(OP_FREE, 5'd0, 8'd7);
      send_request(OP_FREE, 5'd0, 8'd200);
      send_request(OP_ALLOC, 5'd2, 8'd0);

      write_frame_count(9'd2);
      send_request(OP_REBUILD, 5'd0, 8'd0);
      send_request(OP_ALLOC, 5'd1, 8'd0);
      send_request(OP_ALLOC, 5'd1, 8'd0);
      send_request(OP_ALLOC, 5'd0, 8'd0);
      send_request(OP_FREE, 5'd0, 8'd1);
      send_request(OP_ALLOC, 5'd1, 8'd0);
      send_request(OP_FREE, 5'd0, 8'd9);
      send_request(OP_ALLOC, 5'd1, 8'd0);

      phase_counts = '{9'd3, 9'd256, 9'd17, 9'd511, 9'd0,
                       FC_W'($urandom_range(2, 256)), 9'd300, 9'd64};
      for (int p = 0; p < 8; p++) begin
         write_frame_count(phase_counts[p]);
         send_request(OP_REBUILD, 5'd0, 8'd0);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            idle_burst(p != 7);
            send_random_item();
         end
      end

      drain();
      $display("Sent %0d request beats under %0d frame_count writes, checked %0d response beats",
               requests_sent, csr_writes, alloc_sb.beats_checked);
      $display("Allocates granted %0d, refused %0d", alloc_sb.grants, alloc_sb.refusals);
      if (alloc_sb.errors == 0 && alloc_sb.expected_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### page_frame_free_list_allocator.f
design/pffa_pkg.sv
design/pffa_front.sv
design/pffa_queue.sv
design/pffa_back.sv
design/page_frame_free_list_allocator.sv
test/page_frame_free_list_allocator_tb.sv
